@@ sv/fbd_pkg.sv @@
// shared constants and control types for the framebuffer draw engine
`default_nettype none

package fbd_pkg;

  // command kinds
  localparam logic [2:0] KIND_PIXEL = 3'd0;
  localparam logic [2:0] KIND_RECT  = 3'd1;
  localparam logic [2:0] KIND_GLYPH = 3'd2;
  localparam logic [2:0] KIND_CLEAR = 3'd3;
  localparam logic [2:0] KIND_READ  = 3'd4;

  // width of clip arithmetic: a 10-bit coordinate plus a 10-bit extent
  localparam int unsigned CW = 11;

  // pixels in one glyph row
  localparam int unsigned GLYPH_WIDTH = 8;
  localparam int unsigned GW = $clog2(GLYPH_WIDTH);

  // sequencer to raster unit
  typedef struct packed {
    logic load_clip;
    logic load_start;
    logic step;
  } raster_ctrl_t;

  // raster unit to sequencer
  typedef struct packed {
    logic          empty;
    logic          last;
    logic [GW-1:0] glyph_idx;
  } raster_stat_t;

endpackage

`default_nettype wire

@@ sv/framebuffer_draw_engine.sv @@
// top level: command sequencer, raster unit, pixel memory and result register
//
//   channel   signals                                 direction
//   command   in_valid_i, in_stall_o, kind_i .. bits   in
//   result    out_valid_o, out_stall_i, read_color_o   out
//
// each command passes acceptance, clip setup (ST_SETUP) and walk setup (ST_START),
// then writes each clipped pixel in ST_DRAW at one memory write per cycle; a read
// reads its pixel in ST_DRAW, or skips it when off screen, and then loads the
// result register in ST_RWAIT once the result channel is free.
// after reset a clearing pass over the whole screen runs with
// in_stall_o high; a finished read waits in place while a result is stalled.
`default_nettype none

module framebuffer_draw_engine #(
  parameter int unsigned SCREEN_WIDTH  = 96,
  parameter int unsigned SCREEN_HEIGHT = 64
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_stall_o,
  input  wire logic [2:0]        kind_i,
  input  wire logic signed [9:0] pos_x_i,
  input  wire logic signed [9:0] pos_y_i,
  input  wire logic signed [9:0] rect_width_i,
  input  wire logic signed [9:0] rect_height_i,
  input  wire logic [15:0]       color_i,
  input  wire logic [15:0]       back_color_i,
  input  wire logic [7:0]        glyph_bits_i,
  output logic                   out_valid_o,
  input  wire logic              out_stall_i,
  output logic [15:0]            read_color_o
);

  localparam int unsigned Depth = SCREEN_WIDTH * SCREEN_HEIGHT;
  localparam int unsigned AW    = (Depth > 1) ? $clog2(Depth) : 1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SETUP,
    ST_START,
    ST_DRAW,
    ST_RWAIT
  } state_e;

  state_e                state_q;
  logic [2:0]            kind_q;
  logic signed [9:0]     pos_x_q, pos_y_q, rect_width_q, rect_height_q;
  logic [15:0]           color_q, back_color_q;
  logic [7:0]            glyph_bits_q;
  logic                  hit_q;
  logic                  out_valid_q;
  logic [15:0]           read_color_q;

  fbd_pkg::raster_ctrl_t ctrl;
  fbd_pkg::raster_stat_t stat;
  logic [AW-1:0]         ram_addr;
  logic                  ram_we, ram_re;
  logic [15:0]           ram_wdata, ram_rdata;
  logic                  is_read, out_free;

  assign is_read  = (kind_q == fbd_pkg::KIND_READ);
  assign out_free = !out_valid_q || !out_stall_i;

  // raster unit control from the sequencer state
  always_comb begin
    ctrl.load_clip  = (state_q == ST_SETUP);
    ctrl.load_start = (state_q == ST_START);
    ctrl.step       = (state_q == ST_DRAW) && !is_read;
  end

  // memory access and glyph color selection
  assign ram_we    = (state_q == ST_DRAW) && !is_read;
  assign ram_re    = (state_q == ST_DRAW) && is_read;
  assign ram_wdata = (kind_q != fbd_pkg::KIND_GLYPH) ? color_q :
                     glyph_bits_q[3'(fbd_pkg::GLYPH_WIDTH - 1) - stat.glyph_idx] ?
                     color_q : back_color_q;

  // sequencer, command register and result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_SETUP;
      kind_q        <= fbd_pkg::KIND_CLEAR;
      pos_x_q       <= '0;
      pos_y_q       <= '0;
      rect_width_q  <= '0;
      rect_height_q <= '0;
      color_q       <= '0;
      back_color_q  <= '0;
      glyph_bits_q  <= '0;
      hit_q         <= 1'b0;
      out_valid_q   <= 1'b0;
      read_color_q  <= '0;
    end else begin
      if (out_valid_q && !out_stall_i && (state_q != ST_RWAIT)) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (in_valid_i) begin
            kind_q        <= kind_i;
            pos_x_q       <= pos_x_i;
            pos_y_q       <= pos_y_i;
            rect_width_q  <= rect_width_i;
            rect_height_q <= rect_height_i;
            color_q       <= color_i;
            back_color_q  <= back_color_i;
            glyph_bits_q  <= glyph_bits_i;
            state_q       <= ST_SETUP;
          end
        end
        ST_SETUP: begin
          state_q <= ST_START;
        end
        ST_START: begin
          hit_q <= 1'b0;
          if (!stat.empty) begin
            state_q <= ST_DRAW;
          end else if (is_read) begin
            state_q <= ST_RWAIT;
          end else begin
            state_q <= ST_IDLE;
          end
        end
        ST_DRAW: begin
          if (is_read) begin
            hit_q   <= 1'b1;
            state_q <= ST_RWAIT;
          end else if (stat.last) begin
            state_q <= ST_IDLE;
          end
        end
        ST_RWAIT: begin
          if (out_free) begin
            out_valid_q  <= 1'b1;
            read_color_q <= hit_q ? ram_rdata : '0;
            state_q      <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign in_stall_o   = (state_q != ST_IDLE);
  assign out_valid_o  = out_valid_q;
  assign read_color_o = read_color_q;

  fbd_raster #(
    .ScreenWidth  (SCREEN_WIDTH),
    .ScreenHeight (SCREEN_HEIGHT),
    .AddrWidth    (AW)
  ) u_raster (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .ctrl_i        (ctrl),
    .kind_i        (kind_q),
    .pos_x_i       (pos_x_q),
    .pos_y_i       (pos_y_q),
    .rect_width_i  (rect_width_q),
    .rect_height_i (rect_height_q),
    .stat_o        (stat),
    .addr_o        (ram_addr)
  );

  fbd_ram #(
    .Depth     (Depth),
    .AddrWidth (AW)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .re_i    (ram_re),
    .addr_i  (ram_addr),
    .wdata_i (ram_wdata),
    .rdata_o (ram_rdata)
  );

  // an accepted transaction starts the clip setup
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> (state_q == ST_SETUP))
    else $error("accepted command did not enter setup");

  // a result appears only after the read wait
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> ($past(state_q) == ST_RWAIT))
    else $error("result without a read");

  // the raster walk stays inside the store
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DRAW) |-> ({1'b0, ram_addr} < (AW + 1)'(Depth)))
    else $error("pixel address beyond the store");

  // a read result never overwrites one still waiting
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(read_color_o)))
    else $error("pending result lost");

endmodule

`default_nettype wire

@@ sv/fbd_ram.sv @@
// single-port pixel memory with registered read data
`default_nettype none

module fbd_ram #(
  parameter int unsigned Depth     = 6144,
  parameter int unsigned AddrWidth = 13
) (
  input  wire logic                 clk_i,
  input  wire logic                 we_i,
  input  wire logic                 re_i,
  input  wire logic [AddrWidth-1:0] addr_i,
  input  wire logic [15:0]          wdata_i,
  output logic      [15:0]          rdata_o
);

  logic [15:0] mem [Depth];
  logic [15:0] rdata_q;

  // up to one write and one read per cycle, both at addr_i
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[addr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

@@ sv/fbd_raster.sv @@
// clip window and raster walk that produces one pixel address per step
`default_nettype none

module fbd_raster #(
  parameter int unsigned ScreenWidth  = 96,
  parameter int unsigned ScreenHeight = 64,
  parameter int unsigned AddrWidth    = 13
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire fbd_pkg::raster_ctrl_t      ctrl_i,
  input  wire logic [2:0]                 kind_i,
  input  wire logic signed [9:0]          pos_x_i,
  input  wire logic signed [9:0]          pos_y_i,
  input  wire logic signed [9:0]          rect_width_i,
  input  wire logic signed [9:0]          rect_height_i,
  output fbd_pkg::raster_stat_t           stat_o,
  output logic [AddrWidth-1:0]            addr_o
);

  localparam int unsigned CW = fbd_pkg::CW;
  localparam logic signed [CW-1:0] Zero = '0;
  localparam logic signed [CW-1:0] One  = CW'(1);
  localparam logic signed [CW-1:0] WS   = CW'(ScreenWidth);
  localparam logic signed [CW-1:0] HS   = CW'(ScreenHeight);
  localparam logic signed [CW-1:0] GS   = CW'(fbd_pkg::GLYPH_WIDTH);

  logic signed [CW-1:0] x0, y0, w, h, xend, yend;
  logic signed [CW-1:0] xs_d, xe_d, ys_d, ye_d;
  logic                 empty_d;
  logic signed [CW-1:0] xs_q, xe_q, ys_q, ye_q, x_q, y_q;
  logic                 empty_q;
  logic [AddrWidth-1:0] row_base_q;
  logic signed [CW-1:0] x_inc, y_inc, x_off;

  // drawing window of the command before clipping
  always_comb begin
    x0 = {pos_x_i[9], pos_x_i};
    y0 = {pos_y_i[9], pos_y_i};
    w  = Zero;
    h  = Zero;
    case (kind_i)
      fbd_pkg::KIND_PIXEL, fbd_pkg::KIND_READ: begin
        w = One;
        h = One;
      end
      fbd_pkg::KIND_RECT: begin
        w = {rect_width_i[9], rect_width_i};
        h = {rect_height_i[9], rect_height_i};
      end
      fbd_pkg::KIND_GLYPH: begin
        w = GS;
        h = One;
      end
      fbd_pkg::KIND_CLEAR: begin
        x0 = Zero;
        y0 = Zero;
        w  = WS;
        h  = HS;
      end
      default: begin
        w = Zero;
        h = Zero;
      end
    endcase
  end

  // clip against the screen
  assign xend    = x0 + w;
  assign yend    = y0 + h;
  assign xs_d    = (x0 < Zero) ? Zero : x0;
  assign ys_d    = (y0 < Zero) ? Zero : y0;
  assign xe_d    = (xend > WS) ? WS : xend;
  assign ye_d    = (yend > HS) ? HS : yend;
  assign empty_d = (w <= Zero) || (h <= Zero) || (xs_d >= xe_d) || (ys_d >= ye_d);

  assign x_inc = x_q + One;
  assign y_inc = y_q + One;
  assign x_off = x_q - x0;

  // window registers and walk counters
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      xs_q       <= Zero;
      xe_q       <= Zero;
      ys_q       <= Zero;
      ye_q       <= Zero;
      empty_q    <= 1'b1;
      x_q        <= Zero;
      y_q        <= Zero;
      row_base_q <= '0;
    end else if (ctrl_i.load_clip) begin
      xs_q    <= xs_d;
      xe_q    <= xe_d;
      ys_q    <= ys_d;
      ye_q    <= ye_d;
      empty_q <= empty_d;
    end else if (ctrl_i.load_start) begin
      x_q        <= xs_q;
      y_q        <= ys_q;
      row_base_q <= AddrWidth'(ys_q[CW-2:0]) * AddrWidth'(ScreenWidth);
    end else if (ctrl_i.step) begin
      if (x_inc == xe_q) begin
        x_q        <= xs_q;
        y_q        <= y_inc;
        row_base_q <= row_base_q + AddrWidth'(ScreenWidth);
      end else begin
        x_q <= x_inc;
      end
    end
  end

  assign addr_o           = row_base_q + AddrWidth'(x_q[CW-2:0]);
  assign stat_o.empty     = empty_q;
  assign stat_o.last      = (x_inc == xe_q) && (y_inc == ye_q);
  assign stat_o.glyph_idx = x_off[fbd_pkg::GW-1:0];

endmodule

`default_nettype wire

@@ bench/tb_framebuffer_draw_engine.sv @@
// self-checking testbench for the framebuffer draw engine with a pixel-store predictor
`timescale 1ns / 1ps

module tb_framebuffer_draw_engine;

  localparam int SCREEN_W = 96;
  localparam int SCREEN_H = 64;
  localparam int STORE_DEPTH = SCREEN_W * SCREEN_H;
  localparam int IDLE_PCT = 26;
  localparam int HOLD_CYCLES = 400;
  localparam int RANDOM_ITEMS = 64;

  // kinds that the block ignores
  localparam logic [2:0] KIND_SPARE_5 = 3'd5;
  localparam logic [2:0] KIND_SPARE_7 = 3'd7;

  typedef struct packed {
    logic [2:0]  kind;
    logic [9:0]  pos_x;
    logic [9:0]  pos_y;
    logic [9:0]  rect_width;
    logic [9:0]  rect_height;
    logic [15:0] color;
    logic [15:0] back_color;
    logic [7:0]  glyph_bits;
  } draw_cmd_t;

  // pixel store predictor and pending read colors
  class frame_scoreboard;
    logic [15:0] pixels [STORE_DEPTH];
    logic [15:0] read_colors [$];
    int mismatches;

    function new();
      foreach (pixels[i]) pixels[i] = 16'h0000;
      mismatches = 0;
    endfunction

    function bit on_screen(int x, int y);
      return x >= 0 && x < SCREEN_W && y >= 0 && y < SCREEN_H;
    endfunction

    function void paint(int x, int y, logic [15:0] c);
      if (on_screen(x, y)) pixels[y * SCREEN_W + x] = c;
    endfunction

    // apply one accepted transaction to the store
    function void note_command(draw_cmd_t c);
      int x, y, w, h, xs, ys, xe, ye, row, col;
      x = $signed(c.pos_x);
      y = $signed(c.pos_y);
      w = $signed(c.rect_width);
      h = $signed(c.rect_height);
      case (c.kind)
        fbd_pkg::KIND_PIXEL: paint(x, y, c.color);
        fbd_pkg::KIND_RECT: begin
          if (w > 0 && h > 0) begin
            xs = (x < 0) ? 0 : x;
            ys = (y < 0) ? 0 : y;
            xe = (x + w > SCREEN_W) ? SCREEN_W : x + w;
            ye = (y + h > SCREEN_H) ? SCREEN_H : y + h;
            for (row = ys; row < ye; row++)
              for (col = xs; col < xe; col++)
                pixels[row * SCREEN_W + col] = c.color;
          end
        end
        fbd_pkg::KIND_GLYPH: begin
          // leftmost pixel comes from the top bit
          for (col = 0; col < fbd_pkg::GLYPH_WIDTH; col++)
            paint(x + col, y, c.glyph_bits[fbd_pkg::GLYPH_WIDTH - 1 - col] ?
                              c.color : c.back_color);
        end
        fbd_pkg::KIND_CLEAR: foreach (pixels[i]) pixels[i] = c.color;
        fbd_pkg::KIND_READ:
          read_colors.push_back(on_screen(x, y) ? pixels[y * SCREEN_W + x] : 16'h0000);
        default: ;
      endcase
    endfunction

    task report_mismatch(string msg);
      $display("mismatch at %0t: %s", $time, msg);
      mismatches++;
    endtask

    task check_result(logic [15:0] got);
      logic [15:0] want;
      if (read_colors.size() == 0) begin
        report_mismatch($sformatf("read result %h with no read outstanding", got));
      end else begin
        want = read_colors.pop_front();
        if (got !== want)
          report_mismatch($sformatf("read_color %h, expected %h", got, want));
      end
    endtask

    function int pending();
      return read_colors.size();
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni;
  logic in_valid_i;
  logic in_stall_o;
  logic [2:0] kind_i;
  logic signed [9:0] pos_x_i;
  logic signed [9:0] pos_y_i;
  logic signed [9:0] rect_width_i;
  logic signed [9:0] rect_height_i;
  logic [15:0] color_i;
  logic [15:0] back_color_i;
  logic [7:0] glyph_bits_i;
  logic out_valid_o;
  logic out_stall_i;
  logic [15:0] read_color_o;

  frame_scoreboard scoreboard;
  bit quiet;
  int hold_asks;
  int last_x, last_y;

  framebuffer_draw_engine dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .kind_i        (kind_i),
    .pos_x_i       (pos_x_i),
    .pos_y_i       (pos_y_i),
    .rect_width_i  (rect_width_i),
    .rect_height_i (rect_height_i),
    .color_i       (color_i),
    .back_color_i  (back_color_i),
    .glyph_bits_i  (glyph_bits_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .read_color_o  (read_color_o)
  );

  // 12 ns clock
  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  function automatic bit idle_now();
    return !quiet && ($urandom_range(99) < IDLE_PCT);
  endfunction

  function automatic draw_cmd_t make_cmd(logic [2:0] k, int x, int y, int w, int h,
                                         logic [15:0] fg, logic [15:0] bg, logic [7:0] bits);
    draw_cmd_t c;
    c.kind = k;
    c.pos_x = 10'(x);
    c.pos_y = 10'(y);
    c.rect_width = 10'(w);
    c.rect_height = 10'(h);
    c.color = fg;
    c.back_color = bg;
    c.glyph_bits = bits;
    return c;
  endfunction

  // mostly near the screen, sometimes anywhere in the field
  function automatic int pick_coord(int span);
    if ($urandom_range(99) < 12) return $signed(10'($urandom()));
    return int'($urandom_range(span + 7)) - 4;
  endfunction

  function automatic int pick_extent();
    int r;
    r = $urandom_range(99);
    if (r < 8) return $signed(10'($urandom()));
    if (r < 16) return -int'($urandom_range(3));
    return int'($urandom_range(1, 16));
  endfunction

  // offer one transaction, with random idle cycles ahead of it
  task automatic send(input draw_cmd_t c);
    @(negedge clk_i);
    while (idle_now()) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    kind_i <= c.kind;
    pos_x_i <= c.pos_x;
    pos_y_i <= c.pos_y;
    rect_width_i <= c.rect_width;
    rect_height_i <= c.rect_height;
    color_i <= c.color;
    back_color_i <= c.back_color;
    glyph_bits_i <= c.glyph_bits;
    do @(posedge clk_i); while (in_stall_o);
    scoreboard.note_command(c);
  endtask

  task automatic idle_sender();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
  endtask

  // result side: random stall, plus long hold-offs on request
  initial begin : receiver
    int hold_left;
    int hold_served;
    hold_left = 0;
    hold_served = 0;
    out_stall_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_asks != hold_served) begin
        hold_served = hold_asks;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        out_stall_i <= 1'b1;
        hold_left--;
      end else begin
        out_stall_i <= idle_now();
      end
    end
  end

  // check every accepted result
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i)
      scoreboard.check_result(read_color_o);
  end

  initial begin : stimulus
    draw_cmd_t c;
    int drawn;
    int r;
    int wait_cycles;
    scoreboard = new();
    quiet = 1'b0;
    hold_asks = 0;
    last_x = 0;
    last_y = 0;
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    kind_i = fbd_pkg::KIND_PIXEL;
    pos_x_i = '0;
    pos_y_i = '0;
    rect_width_i = '0;
    rect_height_i = '0;
    color_i = '0;
    back_color_i = '0;
    glyph_bits_i = '0;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // directed: corners, clipping, empty rects, glyph edges, clear, ignored kinds
    send(make_cmd(fbd_pkg::KIND_READ, 0, 0, 0, 0, 16'h0, 16'h0, 8'h00));
    send(make_cmd(fbd_pkg::KIND_READ, 95, 63, 0, 0, 16'h0, 16'h0, 8'h00));
    send(make_cmd(fbd_pkg::KIND_PIXEL, 0, 0, 0, 0, 16'hFFFF, 16'h0, 8'h00));
    send(make_cmd(fbd_pkg::KIND_PIXEL, 95, 63, 0, 0, 16'h8001, 16'h0, 8'h00));
    send(make_cmd(fbd_pkg::KIND_READ, 0, 0, 0, 0, 16'h0, 16'h0, 8'h00));
    send(make_cmd(fbd_pkg::KIND_READ, 95, 63, 0, 0, 16'h0, 16'h0, 8'h00));
    send(make_cmd(fbd_pkg::KIND_PIXEL, -1, 0, 0, 0, 16'h1111, 16'h0, 8'h00));
    send(make_cmd(fbd_pkg::KIND_PIXEL, 96, 63, 0, 0, 16'h2222, 16'h0, 8'h00));
    send(make_cmd(fbd_pkg::KIND_READ, -512, 0, 0, 0, 16'h0, 16'h0, 8'h00));
    send(make_cmd(fbd_pkg::KIND_READ, 0, 511, 0, 0, 16'h0, 16'h0, 8'h00));
    send(make_cmd(fbd_pkg::KIND_RECT, 10, 10, 0, 5, 16'h3333, 16'h0, 8'h00));
    send(make_cmd(fbd_pkg::KIND_RECT, 10, 10, 5, -512, 16'h3333, 16'h0, 8'h00));
    send(make_cmd(fbd_pkg::KIND_READ, 10, 10, 0, 0, 16'h0, 16'h0, 8'h00));
    send(make_cmd(fbd_pkg::KIND_RECT, -4, -4, 10, 10, 16'hABCD, 16'h0, 8'h00));
    send(make_cmd(fbd_pkg::KIND_RECT, 90, 60, 511, 511, 16'h5555, 16'h0, 8'h00));
    send(make_cmd(fbd_pkg::KIND_READ, 5, 5, 0, 0, 16'h0, 16'h0, 8'h00));
    send(make_cmd(fbd_pkg::KIND_READ, 95, 63, 0, 0, 16'h0, 16'h0, 8'h00));
    send(make_cmd(fbd_pkg::KIND_GLYPH, -3, 20, 0, 0, 16'hF800, 16'h07E0, 8'hA5));
    send(make_cmd(fbd_pkg::KIND_GLYPH, 92, 63, 0, 0, 16'hFFFF, 16'h0000, 8'h81));
    send(make_cmd(fbd_pkg::KIND_READ, 0, 20, 0, 0, 16'h0, 16'h0, 8'h00));
    send(make_cmd(fbd_pkg::KIND_READ, 95, 63, 0, 0, 16'h0, 16'h0, 8'h00));
    send(make_cmd(fbd_pkg::KIND_CLEAR, 511, -512, 511, -512, 16'h001F, 16'hFFFF, 8'hFF));
    send(make_cmd(fbd_pkg::KIND_READ, 47, 31, 0, 0, 16'h0, 16'h0, 8'h00));
    send(make_cmd(KIND_SPARE_5, 3, 3, 4, 4, 16'hFFFF, 16'hFFFF, 8'hFF));
    send(make_cmd(KIND_SPARE_7, 3, 3, 4, 4, 16'hFFFF, 16'hFFFF, 8'hFF));

    // random traffic
    drawn = 0;
    while (drawn < RANDOM_ITEMS) begin
      quiet = (drawn >= 30 && drawn < 50);

      // block the result side and keep reading until the block backs up
      if (drawn == 15) begin
        hold_asks++;
        repeat (12)
          send(make_cmd(fbd_pkg::KIND_READ, last_x, last_y, 0, 0, 16'h0, 16'h0, 8'h00));
      end

      // let everything drain before going on
      if (drawn == 55) begin
        idle_sender();
        while (scoreboard.pending() != 0) @(posedge clk_i);
      end

      c = make_cmd(fbd_pkg::KIND_PIXEL, pick_coord(SCREEN_W), pick_coord(SCREEN_H),
                   pick_extent(), pick_extent(), 16'($urandom()), 16'($urandom()),
                   8'($urandom()));
      r = $urandom_range(99);
      if (r < 20) c.kind = fbd_pkg::KIND_PIXEL;
      else if (r < 38) c.kind = fbd_pkg::KIND_RECT;
      else if (r < 56) c.kind = fbd_pkg::KIND_GLYPH;
      else if (r < 59) c.kind = fbd_pkg::KIND_CLEAR;
      else if (r < 94) c.kind = fbd_pkg::KIND_READ;
      else c.kind = 3'($urandom_range(KIND_SPARE_5, KIND_SPARE_7));

      // half of the reads revisit the last drawn spot
      if (c.kind == fbd_pkg::KIND_READ && $urandom_range(1) == 1) begin
        c.pos_x = 10'(last_x);
        c.pos_y = 10'(last_y);
      end
      if (c.kind inside {fbd_pkg::KIND_PIXEL, fbd_pkg::KIND_RECT, fbd_pkg::KIND_GLYPH}) begin
        last_x = $signed(c.pos_x) +
                 ((c.kind == fbd_pkg::KIND_GLYPH) ? int'($urandom_range(7)) : 0);
        last_y = $signed(c.pos_y);
      end

      send(c);
      drawn++;
    end
    quiet = 1'b0;

    // drain, then allow the longest write to finish
    idle_sender();
    for (wait_cycles = 0; wait_cycles < 20000 && scoreboard.pending() != 0; wait_cycles++)
      @(posedge clk_i);
    repeat (STORE_DEPTH + 16) @(posedge clk_i);
    if (scoreboard.pending() != 0)
      scoreboard.report_mismatch($sformatf("%0d read results never arrived",
                                           scoreboard.pending()));

    if (scoreboard.mismatches == 0) begin
      $display("framebuffer_draw_engine regression: pass");
    end else begin
      $display("framebuffer_draw_engine regression: fail");
    end
    $finish;
  end

  // watchdog
  initial begin
    #60ms;
    $display("framebuffer_draw_engine regression: fail");
    $finish;
  end

endmodule
